@@ hw/rtl/base32_stream_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// base32 stream decoder assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef BASE32_STREAM_DECODER_DEFINES_SVH
`define BASE32_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, held off during reset
`define B32D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b32d check failed");

// next-cycle implication, held off during reset
`define B32D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b32d check failed");

`endif

@@ hw/rtl/b32d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_pkg
// shared types, constants and the symbol map of the base32 decoder
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_EQ = 8'h3D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UZ = 8'h5A;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LZ = 8'h7A;
    localparam logic [7:0] CHAR_D2 = 8'h32;
    localparam logic [7:0] CHAR_D7 = 8'h37;
    localparam logic [7:0] DIGIT_BASE = 8'd26;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // one request's worth of work for the back part
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       has_status;
        logic       bad;
    } t_rec;

    // symbol map: bit 5 is valid, bits 4:0 the 5-bit value
    function automatic logic [5:0] map_symbol(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CHAR_UA && c <= CHAR_UZ) begin
                d = c - CHAR_UA;
                map_symbol = {1'b1, d[4:0]};
            end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
                d = c - CHAR_LA;
                map_symbol = {1'b1, d[4:0]};
            end else if (c >= CHAR_D2 && c <= CHAR_D7) begin
                d = c - CHAR_D2 + DIGIT_BASE;
                map_symbol = {1'b1, d[4:0]};
            end else begin
                map_symbol = 6'd0;
            end
        end
    endfunction

    function automatic logic is_trailer(input logic [7:0] c);
        is_trailer = (c == CHAR_EQ) || (c == CHAR_LF) || (c == CHAR_CR) || (c == CHAR_SP);
    endfunction

endpackage

@@ hw/rtl/b32d_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_front
// classifies each character, keeps the bit residue and builds a work record
// ----------------------------------------------------------------------------
module b32d_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_character,
    input  logic                i_has_char,
    input  logic                i_is_last,
    output b32d_pkg::t_rec      o_rec,
    output logic                o_rec_push
);

    logic [6:0]  r_res_bits, n_res_bits;
    logic [2:0]  r_res_cnt,  n_res_cnt;
    logic [2:0]  r_chars,    n_chars;
    logic        r_trailer,  n_trailer;
    logic        r_failed,   n_failed;

    logic [5:0]  sym;
    logic        trl;
    logic [11:0] acc;
    logic [3:0]  cnt;
    logic [11:0] shifted;

    assign sym = b32d_pkg::map_symbol(i_character);
    assign trl = b32d_pkg::is_trailer(i_character);
    assign acc = {r_res_bits, sym[4:0]};
    assign cnt = {1'b0, r_res_cnt} + 4'd5;
    assign shifted = acc >> cnt[2:0];

    always_comb begin
        n_res_bits = r_res_bits;
        n_res_cnt  = r_res_cnt;
        n_chars    = r_chars;
        n_trailer  = r_trailer;
        n_failed   = r_failed;
        o_rec      = '0;
        o_rec_push = 1'b0;
        if (i_accept) begin
            if (i_has_char) begin
                if (trl) begin
                    n_trailer = 1'b1;
                end else if (!sym[5] || r_trailer) begin
                    n_failed = 1'b1;
                end else if (!r_failed) begin
                    // a byte is due once eight bits have gathered
                    if (cnt[3]) begin
                        o_rec.has_byte = 1'b1;
                        o_rec.data     = shifted[7:0];
                    end
                    n_res_cnt  = cnt[2:0];
                    n_res_bits = acc[6:0] & ~(7'h7F << cnt[2:0]);
                    n_chars    = r_chars + 3'd1;
                end
            end
            if (i_is_last) begin
                o_rec.has_status = 1'b1;
                o_rec.bad = n_failed || (n_chars == 3'd1) || (n_chars == 3'd3)
                            || (n_chars == 3'd6) || (n_res_bits != 7'd0);
                n_res_bits = 7'd0;
                n_res_cnt  = 3'd0;
                n_chars    = 3'd0;
                n_trailer  = 1'b0;
                n_failed   = 1'b0;
            end
            o_rec_push = o_rec.has_byte || o_rec.has_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_bits <= 7'd0;
            r_res_cnt  <= 3'd0;
            r_chars    <= 3'd0;
            r_trailer  <= 1'b0;
            r_failed   <= 1'b0;
        end else begin
            r_res_bits <= n_res_bits;
            r_res_cnt  <= n_res_cnt;
            r_chars    <= n_chars;
            r_trailer  <= n_trailer;
            r_failed   <= n_failed;
        end
    end

endmodule

@@ hw/rtl/b32d_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_queue
// short record queue between the front and back parts
// ----------------------------------------------------------------------------
module b32d_queue #(
    parameter int P_DEPTH = b32d_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  b32d_pkg::t_rec i_rec,
    input  logic           i_rd,
    output b32d_pkg::t_rec o_rec,
    output logic           o_valid,
    output logic           o_full
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    b32d_pkg::t_rec r_mem [P_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;
    logic           wr_en, rd_en;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hw/rtl/b32d_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_back
// expands records into results and holds the output register
// ----------------------------------------------------------------------------
module b32d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  b32d_pkg::t_rec i_rec,
    input  logic           i_rec_valid,
    output logic           o_rec_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_data_byte,
    output logic           o_final_res
);

    logic              r_valid, n_valid;
    logic              r_phase, n_phase;
    b32d_pkg::t_kind   r_kind,  n_kind;
    logic [7:0]        r_byte,  n_byte;
    logic              r_final, n_final;
    logic              load;

    assign load = i_rec_valid && (!r_valid || i_pop);

    always_comb begin
        n_valid   = r_valid && !i_pop;
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_byte    = r_byte;
        n_final   = r_final;
        o_rec_pop = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (!r_phase && i_rec.has_byte) begin
                n_kind    = b32d_pkg::KIND_DATA;
                n_byte    = i_rec.data;
                n_final   = 1'b0;
                o_rec_pop = !i_rec.has_status;
                n_phase   = i_rec.has_status;
            end else begin
                n_kind    = i_rec.bad ? b32d_pkg::KIND_ERR : b32d_pkg::KIND_OK;
                n_byte    = 8'd0;
                n_final   = 1'b1;
                o_rec_pop = 1'b1;
                n_phase   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_byte  <= n_byte;
        r_final <= n_final;
    end

    assign o_empty     = !r_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_byte;
    assign o_final_res = r_final;

endmodule

@@ hw/rtl/base32_stream_decoder.sv @@
`timescale 1ns / 1ps
// path: a request's record is written into the record queue, then loaded into the output register of the back part
// throughput: one character per cycle while the queue has room; results leave at one per cycle
//   while popped; a request with a data byte and a status emits them in turn and the queue absorbs the surplus
// reset: synchronous active-low i_rst_n empties the queue and output stage and returns
//   the decode state to the start of a stream
// ----------------------------------------------------------------------------
// base32_stream_decoder
// streaming base32 decoder with a decoupled front part, record queue and back part
// ----------------------------------------------------------------------------
module base32_stream_decoder #(
    parameter int P_QUEUE_DEPTH = b32d_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input request side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_character,
    input  logic       i_has_char,
    input  logic       i_is_last,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_final_res
);

    b32d_pkg::t_rec front_rec;
    b32d_pkg::t_rec head_rec;
    logic           front_push;
    logic           accept;
    logic           head_valid;
    logic           head_pop;

    // a request is taken whenever the record queue has room; the front part updates
    // its residue in the same cycle so characters can arrive every clock
    assign accept = push && !full;

    // front: symbol map, trailer tracking, residue shift and end-of-stream check
    b32d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_character (i_character),
        .i_has_char  (i_has_char),
        .i_is_last   (i_is_last),
        .o_rec       (front_rec),
        .o_rec_push  (front_push)
    );

    // queue: holds records while the result side stalls; its full flag is the
    // input backpressure, so no record is ever dropped
    b32d_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_push),
        .i_rec   (front_rec),
        .i_rd    (head_pop),
        .o_rec   (head_rec),
        .o_valid (head_valid),
        .o_full  (full)
    );

    // back: turns each record into a data byte and/or a final status, in that order
    b32d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (head_rec),
        .i_rec_valid (head_valid),
        .o_rec_pop   (head_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_final_res (o_final_res)
    );

endmodule

@@ hw/rtl/b32d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32d_checker
// port-level checks bound to the base32 stream decoder
// ----------------------------------------------------------------------------
`include "base32_stream_decoder_defines.svh"

module b32d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_kind,
    input logic [7:0] o_data_byte,
    input logic       o_final_res
);

    logic        is_status;
    logic [10:0] res_word;

    assign is_status = (o_kind != b32d_pkg::KIND_DATA);
    assign res_word  = {o_kind, o_data_byte, o_final_res};

    // final flag marks exactly the status results
    `B32D_ASSERT_NOW(a_final_is_status, i_clk, i_rst_n, !empty, o_final_res == is_status)

    // status results carry a zero byte
    `B32D_ASSERT_NOW(a_status_zero_byte, i_clk, i_rst_n, !empty && is_status, o_data_byte == 8'd0)

    // a waiting result holds until taken
    `B32D_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(res_word))

    // a full block stays full until a result leaves
    `B32D_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, full && !pop, full)

endmodule

bind base32_stream_decoder b32d_checker u_b32d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_kind      (o_kind),
    .o_data_byte (o_data_byte),
    .o_final_res (o_final_res)
);

@@ tb/base32_stream_decoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_stream_decoder_checker
// watches both queue sides of the decoder, decodes each accepted request on
// its own and compares every popped result with the oldest one it expects
// ----------------------------------------------------------------------------
module base32_stream_decoder_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_character,
    input  logic       i_has_char,
    input  logic       i_is_last,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_res,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        b32d_pkg::t_kind kind;
        logic [7:0]      data;
        logic            is_final;
    } t_decoded;

    t_decoded   decoded_q[$];

    // decode state of the current stream
    logic [7:0] leftover_bits;
    logic [2:0] leftover_len;
    logic [2:0] symbol_count;
    logic       padding_seen;
    logic       stream_bad;

    initial o_fail_count = 0;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic clear_stream();
        leftover_bits = '0;
        leftover_len  = '0;
        symbol_count  = '0;
        padding_seen  = 1'b0;
        stream_bad    = 1'b0;
    endtask

    // 5-bit symbol value; returns 0 on a byte outside the alphabet
    function automatic logic symbol_of(input logic [7:0] c, output logic [4:0] value);
        value = '0;
        symbol_of = 1'b1;
        if (c >= b32d_pkg::CHAR_D2 && c <= b32d_pkg::CHAR_D7)
            value = 5'(c - b32d_pkg::CHAR_D2 + 8'd26);
        else if (c >= b32d_pkg::CHAR_UA && c <= b32d_pkg::CHAR_UZ)
            value = 5'(c - b32d_pkg::CHAR_UA);
        else if (c >= b32d_pkg::CHAR_LA && c <= b32d_pkg::CHAR_LZ)
            value = 5'(c - b32d_pkg::CHAR_LA);
        else
            symbol_of = 1'b0;
    endfunction

    task automatic decode_request(input logic [7:0] c, input logic has, input logic last);
        logic [12:0] acc;
        logic [4:0]  value;
        logic        known;
        logic        bad;
        int          nbits;
        if (has) begin
            if (c == b32d_pkg::CHAR_EQ || c == b32d_pkg::CHAR_CR ||
                c == b32d_pkg::CHAR_LF || c == b32d_pkg::CHAR_SP) begin
                padding_seen = 1'b1;
            end else begin
                known = symbol_of(c, value);
                if (!known || padding_seen) begin
                    stream_bad = 1'b1;
                end else if (!stream_bad) begin
                    acc   = {leftover_bits, value};
                    nbits = leftover_len + 5;
                    if (nbits >= 8) begin
                        nbits -= 8;
                        decoded_q.push_back('{kind: b32d_pkg::KIND_DATA,
                                              data: 8'(acc >> nbits),
                                              is_final: 1'b0});
                    end
                    leftover_len  = 3'(nbits);
                    leftover_bits = 8'(acc & ((13'd1 << nbits) - 13'd1));
                    symbol_count  = symbol_count + 3'd1;
                end
            end
        end
        if (last) begin
            bad = stream_bad || leftover_bits != 0 ||
                  symbol_count == 3'd1 || symbol_count == 3'd3 || symbol_count == 3'd6;
            decoded_q.push_back('{kind: bad ? b32d_pkg::KIND_ERR : b32d_pkg::KIND_OK,
                                  data: 8'd0, is_final: 1'b1});
            clear_stream();
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            decoded_q.delete();
            clear_stream();
        end else begin
            if (i_pop && !i_empty) begin
                if (decoded_q.size() == 0) begin
                    report($sformatf("result kind %0d data %0d with nothing outstanding",
                                     i_kind, i_data_byte));
                end else begin
                    want = decoded_q.pop_front();
                    if (i_kind !== want.kind)
                        report($sformatf("kind %0d, want %0d", i_kind, want.kind));
                    if (i_data_byte !== want.data)
                        report($sformatf("data_byte %0d, want %0d", i_data_byte, want.data));
                    if (i_final_res !== want.is_final)
                        report($sformatf("final_res %0d, want %0d", i_final_res,
                                         want.is_final));
                end
            end
            if (i_push && !i_full)
                decode_request(i_character, i_has_char, i_is_last);
        end
        o_pending <= decoded_q.size();
    end

endmodule

@@ tb/base32_stream_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_stream_decoder_tb
// drives character streams into the decoder: a few hand-picked streams for
// the corner cases, then randomly encoded streams with occasional damage and
// raw noise; both queue sides idle at random and the result side once holds
// off long enough to back the block up; the checker does all comparing
// ----------------------------------------------------------------------------
module base32_stream_decoder_tb;

    localparam int ITEM_TARGET  = 400;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0] c;
        logic       has;
    } t_char_req;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] character;
    logic       has_char;
    logic       is_last;
    logic       empty;
    logic       pop;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       final_res;

    int         fail_count;
    int         pending;
    int         cycle_count;
    int         chars_sent;
    int         results_taken;
    logic       sender_calm;
    logic       receiver_calm;
    logic       receiver_holding;
    t_char_req  stream_q[$];

    // all inputs known from time zero, reset held low
    initial begin
        rst_n            = 1'b0;
        push             = 1'b0;
        pop              = 1'b0;
        character        = 8'd0;
        has_char         = 1'b0;
        is_last          = 1'b0;
        cycle_count      = 0;
        chars_sent       = 0;
        results_taken    = 0;
        sender_calm      = 1'b0;
        receiver_calm    = 1'b0;
        receiver_holding = 1'b0;
    end

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    base32_stream_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_character (character),
        .i_has_char  (has_char),
        .i_is_last   (is_last),
        .empty       (empty),
        .pop         (pop),
        .o_kind      (kind),
        .o_data_byte (data_byte),
        .o_final_res (final_res)
    );

    base32_stream_decoder_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_character  (character),
        .i_has_char   (has_char),
        .i_is_last    (is_last),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_kind       (kind),
        .i_data_byte  (data_byte),
        .i_final_res  (final_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // ------------------------------------------------------------------
    // character helpers
    // ------------------------------------------------------------------

    // true for any byte the decoder treats as alphabet or padding
    function automatic logic known_char(input logic [7:0] c);
        known_char = (c >= b32d_pkg::CHAR_UA && c <= b32d_pkg::CHAR_UZ) ||
                     (c >= b32d_pkg::CHAR_LA && c <= b32d_pkg::CHAR_LZ) ||
                     (c >= b32d_pkg::CHAR_D2 && c <= b32d_pkg::CHAR_D7) ||
                     c == b32d_pkg::CHAR_EQ || c == b32d_pkg::CHAR_CR ||
                     c == b32d_pkg::CHAR_LF || c == b32d_pkg::CHAR_SP;
    endfunction

    // alphabet character for a 5-bit value, letters in random case
    function automatic logic [7:0] symbol_char(input logic [4:0] value);
        if (value >= 5'd26)
            symbol_char = b32d_pkg::CHAR_D2 + 8'(value - 5'd26);
        else if ($urandom_range(0, 1) == 0)
            symbol_char = b32d_pkg::CHAR_UA + 8'(value);
        else
            symbol_char = b32d_pkg::CHAR_LA + 8'(value);
    endfunction

    function automatic logic [7:0] padding_char();
        case ($urandom_range(0, 7))
            0:       padding_char = b32d_pkg::CHAR_CR;
            1:       padding_char = b32d_pkg::CHAR_LF;
            2:       padding_char = b32d_pkg::CHAR_SP;
            default: padding_char = b32d_pkg::CHAR_EQ;
        endcase
    endfunction

    function automatic logic [7:0] foreign_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (known_char(c))
            c = 8'($urandom_range(0, 255));
        foreign_char = c;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one request: optional idle gap, then hold push until it is taken.
    // push only drops when a gap follows, so back-to-back requests keep it high
    task automatic send_request(input logic [7:0] c, input logic has, input logic last);
        int gap;
        gap = (sender_calm || receiver_holding) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        character <= c;
        has_char  <= has;
        is_last   <= last;
        @(posedge clk);
        while (full) @(posedge clk);
        if (has || last)
            chars_sent++;
    endtask

    // ascii text as one stream, last character optionally closing it
    task automatic send_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], 1'b1, close && i == s.len() - 1);
    endtask

    // sends the built stream; an empty one is closed by a bare end marker
    task automatic send_stream();
        if (stream_q.size() == 0) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
            for (int i = 0; i < stream_q.size(); i++)
                send_request(stream_q[i].c, stream_q[i].has, i == stream_q.size() - 1);
        end
    endtask

    // properly encoded random bytes, then light damage now and then
    task automatic build_encoded_stream();
        int          nbytes;
        int          acc;
        int          nbits;
        int          npad;
        int          pos;
        logic [7:0]  b;
        nbytes = $urandom_range(0, 6);
        acc    = 0;
        nbits  = 0;
        stream_q.delete();
        for (int i = 0; i < nbytes; i++) begin
            b     = 8'($urandom_range(0, 255));
            acc   = (acc << 8) | b;
            nbits += 8;
            while (nbits >= 5) begin
                nbits -= 5;
                stream_q.push_back('{c: symbol_char(5'(acc >> nbits)), has: 1'b1});
                acc &= (1 << nbits) - 1;
            end
        end
        if (nbits > 0)
            stream_q.push_back('{c: symbol_char(5'(acc << (5 - nbits))), has: 1'b1});
        // padding up to the next multiple of eight, or a random run of it
        npad = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3)
                                           : (8 - stream_q.size() % 8) % 8;
        repeat (npad) stream_q.push_back('{c: padding_char(), has: 1'b1});

        // damage: a stray byte, data behind the padding, a changed symbol
        if (stream_q.size() > 0 && $urandom_range(0, 7) == 0) begin
            pos = $urandom_range(0, stream_q.size() - 1);
            stream_q[pos] = '{c: foreign_char(), has: 1'b1};
        end
        if ($urandom_range(0, 9) == 0) begin
            stream_q.push_back('{c: padding_char(), has: 1'b1});
            stream_q.push_back('{c: symbol_char(5'($urandom_range(0, 31))), has: 1'b1});
        end
        if (stream_q.size() > 0 && $urandom_range(0, 7) == 0) begin
            pos = $urandom_range(0, stream_q.size() - 1);
            stream_q[pos] = '{c: symbol_char(5'($urandom_range(0, 31))), has: 1'b1};
        end
        // requests without a character scattered in, or a bare closing marker
        if (stream_q.size() > 0 && $urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, stream_q.size() - 1);
            stream_q.insert(pos, '{c: 8'($urandom_range(0, 255)), has: 1'b0});
        end
        if ($urandom_range(0, 7) == 0)
            stream_q.push_back('{c: 8'($urandom_range(0, 255)), has: 1'b0});
    endtask

    // raw noise: any byte, character present or not
    task automatic build_noise_stream();
        int n;
        n = $urandom_range(1, 8);
        stream_q.delete();
        repeat (n)
            stream_q.push_back('{c: 8'($urandom_range(0, 255)),
                                 has: ($urandom_range(0, 5) != 0)});
    endtask

    // ------------------------------------------------------------------
    // result side: random pop gaps, stretches with none, one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int gap;
        logic held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held && results_taken >= 40) begin
                // stop popping long enough for the block to fill and stall push
                receiver_holding = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                receiver_holding = 1'b0;
                held = 1'b1;
            end
            if (results_taken % 30 == 0)
                receiver_calm = ($urandom_range(0, 2) == 0);
            gap = receiver_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            results_taken++;
        end
    end

    // timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL base32_stream_decoder");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stream closes with success
        send_request(8'h00, 1'b0, 1'b1);
        // no character and not last: nothing comes out
        send_request(8'hFF, 1'b0, 1'b0);
        // mixed case with every padding character at the tail
        send_text("mY", 1'b0);
        send_request(b32d_pkg::CHAR_EQ, 1'b1, 1'b0);
        send_request(b32d_pkg::CHAR_CR, 1'b1, 1'b0);
        send_request(b32d_pkg::CHAR_LF, 1'b1, 1'b0);
        send_request(b32d_pkg::CHAR_SP, 1'b1, 1'b1);
        // alphabet extremes; tail leaves nonzero leftover bits
        send_text("Az27", 1'b1);
        // stray byte, then data that must stay suppressed
        send_request("Z", 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request("a", 1'b1, 1'b1);
        // data behind padding
        send_text("MY=M", 1'b1);
        // padding only
        send_text("==", 1'b1);

        // random streams, mostly well encoded
        while (chars_sent < ITEM_TARGET) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                build_noise_stream();
            else
                build_encoded_stream();
            send_stream();
        end
        // one more bare end marker: an empty stream
        send_request(8'h00, 1'b0, 1'b1);
        push <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS base32_stream_decoder");
        else
            $display("FAIL base32_stream_decoder");
        $finish;
    end

endmodule

@@ base32_stream_decoder.f @@
+incdir+hw/rtl
hw/rtl/b32d_pkg.sv
hw/rtl/b32d_front.sv
hw/rtl/b32d_queue.sv
hw/rtl/b32d_back.sv
hw/rtl/base32_stream_decoder.sv
hw/rtl/b32d_checker.sv
tb/base32_stream_decoder_checker.sv
tb/base32_stream_decoder_tb.sv
